>>> hdl/tcgr_pkg.sv
// tcgr_pkg: shared types, widths and codes for the text console glyph renderer.
// Used by text_console_glyph_renderer_core; depends on nothing.

package tcgr_pkg;

    // font geometry
    localparam int GLYPH_COUNT  = 95;
    localparam int GLYPH_HEIGHT = 13;
    localparam int GLYPH_WIDTH  = 7;
    localparam int STORE_DEPTH  = GLYPH_COUNT * GLYPH_HEIGHT;
    localparam int FONT_AW      = $clog2(STORE_DEPTH);
    localparam int FONT_DW      = 8;

    // field widths
    localparam int ADDR_W   = 32;
    localparam int PITCH_W  = 16;
    localparam int PIX_W    = 3;
    localparam int COL_W    = 14;
    localparam int ROW_W    = 13;
    localparam int CODE_W   = 8;
    localparam int GIDX_W   = 7;
    localparam int GROW_W   = 4;
    localparam int Y_W      = $clog2(GLYPH_HEIGHT);
    localparam int MASK_W   = GLYPH_WIDTH;
    localparam int LINE_W   = 17;              // cursor_row * GLYPH_HEIGHT
    localparam int PROD_W   = LINE_W + PITCH_W;
    localparam int COLOFF_W = 20;              // cursor_column * GLYPH_WIDTH * pixel_bytes

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // remainder unit for cursor wrap
    localparam int DIV_STEPS = COL_W + 1;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // character codes
    localparam logic [CODE_W-1:0] CODE_FIRST   = 8'h20;
    localparam logic [CODE_W-1:0] CODE_LAST    = 8'h7E;
    localparam logic [CODE_W-1:0] CODE_NEWLINE = 8'h0A;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_BASE   = 3'd0,
        CFG_LINE_PITCH   = 3'd1,
        CFG_PIXEL_BYTES  = 3'd2,
        CFG_TEXT_COLUMNS = 3'd3,
        CFG_TEXT_ROWS    = 3'd4
    } cfg_index_t;

    typedef enum logic {
        ACT_PRINT = 1'b0,
        ACT_FONT  = 1'b1
    } action_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CALC,
        ST_MUL,
        ST_SUM,
        ST_EMIT,
        ST_WRAP
    } state_t;

    typedef struct packed {
        logic              action;
        logic [CODE_W-1:0] char_code;
        logic [GIDX_W-1:0] glyph_index;
        logic [GROW_W-1:0] glyph_row;
        logic [7:0]        row_bits;
    } in_word_t;

    typedef struct packed {
        logic [ADDR_W-1:0] write_address;
        logic [MASK_W-1:0] pixel_mask;
        logic              last_row;
    } out_word_t;

    typedef struct packed {
        logic             need_div;
        logic [COL_W-1:0] value;
    } wrap_t;

    // (pos + 1) mod cnt when it takes at most one compare; flags the rest
    function automatic wrap_t wrap_fast(logic [COL_W:0] inc, logic [COL_W-1:0] cnt);
        wrap_t w;
        w.need_div = 1'b0;
        w.value    = '0;
        if (cnt == '0) begin
            w.value = '0;
        end
        else if (inc == {1'b0, cnt}) begin
            w.value = '0;
        end
        else if (inc < {1'b0, cnt}) begin
            w.value = inc[COL_W-1:0];
        end
        else begin
            w.need_div = 1'b1;
        end
        return w;
    endfunction

endpackage

>>> hdl/tcgr_ram.sv
// tcgr_ram: generic simple dual-port RAM, one write and one registered read port.
// Standalone; no package needed.

module tcgr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> hdl/text_console_glyph_renderer_core.sv
// Text console renderer: font RAM, cursor and glyph row address generator.
// Depends on tcgr_pkg and tcgr_ram.
// Font write, ignored code, newline: done at the accepting edge, busy stays low,
//   except a newline whose row is beyond a lowered count: busy during the row wrap.
// Printable code: setup states CALC, MUL, SUM, then 13 words on consecutive cycles
//   (one font RAM read per cycle); the next item is accepted once the glyph is done,
//   or after the bit-serial remainder unit (15 steps) when the column wrap needs it.
// Reset clears cursor and config registers to their defaults; the font RAM is not cleared.
// Result words cannot be stalled: each is valid for the single cycle strobe is high.

module text_console_glyph_renderer_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  tcgr_pkg::in_word_t                item,
    input  logic                              cfg_write,
    input  logic [tcgr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tcgr_pkg::CFG_DATA_W-1:0]   cfg_data,
    output tcgr_pkg::out_word_t               result,
    output logic                              strobe
);

    localparam logic [tcgr_pkg::Y_W-1:0] LAST_Y = tcgr_pkg::Y_W'(tcgr_pkg::GLYPH_HEIGHT - 1);

    // configuration
    logic [tcgr_pkg::ADDR_W-1:0]  frame_base_reg;
    logic [tcgr_pkg::PITCH_W-1:0] line_pitch_reg;
    logic [tcgr_pkg::PIX_W-1:0]   pixel_bytes_reg;
    logic [tcgr_pkg::COL_W-1:0]   text_columns_reg;
    logic [tcgr_pkg::ROW_W-1:0]   text_rows_reg;

    // control
    tcgr_pkg::state_t             state_reg, state_next;
    logic [tcgr_pkg::COL_W-1:0]   col_reg, col_next;
    logic [tcgr_pkg::ROW_W-1:0]   row_reg, row_next;
    logic [tcgr_pkg::Y_W-1:0]     y_reg, y_next;
    logic [tcgr_pkg::FONT_AW-1:0] rptr_reg, rptr_next;
    logic [tcgr_pkg::DIV_CNT_W-1:0] div_cnt_reg, div_cnt_next;
    logic                         div_row_reg, div_row_next;

    // datapath
    logic [tcgr_pkg::LINE_W-1:0]   row13_reg, row13_next;
    logic [tcgr_pkg::COLOFF_W-1:0] coloff_reg, coloff_next;
    logic [tcgr_pkg::ADDR_W-1:0]   prod_reg, prod_next;
    logic [tcgr_pkg::ADDR_W-1:0]   addr_reg, addr_next;
    logic [tcgr_pkg::COL_W:0]      div_num_reg, div_num_next;
    logic [tcgr_pkg::COL_W:0]      div_rem_reg, div_rem_next;
    logic [tcgr_pkg::COL_W-1:0]    div_den_reg, div_den_next;

    // font RAM
    logic                         font_we;
    logic [tcgr_pkg::FONT_AW-1:0] font_waddr;
    logic                         ram_re;
    logic [tcgr_pkg::FONT_DW-1:0] ram_rdata;

    logic                         printable;
    logic [tcgr_pkg::CODE_W-1:0]  glyph;
    logic [tcgr_pkg::PROD_W-1:0]  mult_full;
    logic [tcgr_pkg::COL_W:0]     div_shift;
    tcgr_pkg::wrap_t              row_wrap, col_wrap;
    logic [tcgr_pkg::MASK_W-1:0]  mask;

    tcgr_ram #(
        .WIDTH (tcgr_pkg::FONT_DW),
        .DEPTH (tcgr_pkg::STORE_DEPTH)
    ) u_font (
        .clk   (clk),
        .we    (font_we),
        .waddr (font_waddr),
        .wdata (item.row_bits),
        .re    (ram_re),
        .raddr (rptr_reg),
        .rdata (ram_rdata)
    );

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_base_reg   <= '0;
            line_pitch_reg   <= tcgr_pkg::PITCH_W'(4096);
            pixel_bytes_reg  <= tcgr_pkg::PIX_W'(4);
            text_columns_reg <= tcgr_pkg::COL_W'(146);
            text_rows_reg    <= tcgr_pkg::ROW_W'(59);
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                tcgr_pkg::CFG_FRAME_BASE:   frame_base_reg   <= cfg_data[tcgr_pkg::ADDR_W-1:0];
                tcgr_pkg::CFG_LINE_PITCH:   line_pitch_reg   <= cfg_data[tcgr_pkg::PITCH_W-1:0];
                tcgr_pkg::CFG_PIXEL_BYTES:  pixel_bytes_reg  <= cfg_data[tcgr_pkg::PIX_W-1:0];
                tcgr_pkg::CFG_TEXT_COLUMNS: text_columns_reg <= cfg_data[tcgr_pkg::COL_W-1:0];
                tcgr_pkg::CFG_TEXT_ROWS:    text_rows_reg    <= cfg_data[tcgr_pkg::ROW_W-1:0];
                default: ;
            endcase
        end
    end

    assign glyph     = item.char_code - tcgr_pkg::CODE_FIRST;
    assign printable = (item.char_code >= tcgr_pkg::CODE_FIRST)
                    && (item.char_code <= tcgr_pkg::CODE_LAST)
                    && (glyph < tcgr_pkg::CODE_W'(tcgr_pkg::GLYPH_COUNT));

    assign font_waddr = tcgr_pkg::FONT_AW'(item.glyph_index)
                      * tcgr_pkg::FONT_AW'(tcgr_pkg::GLYPH_HEIGHT)
                      + tcgr_pkg::FONT_AW'(item.glyph_row);

    assign mult_full = tcgr_pkg::PROD_W'(row13_reg) * tcgr_pkg::PROD_W'(line_pitch_reg);

    assign row_wrap = tcgr_pkg::wrap_fast(tcgr_pkg::COL_W'(row_reg) + (tcgr_pkg::COL_W + 1)'(1),
                                          tcgr_pkg::COL_W'(text_rows_reg));
    assign col_wrap = tcgr_pkg::wrap_fast({1'b0, col_reg} + (tcgr_pkg::COL_W + 1)'(1),
                                          text_columns_reg);

    // one restoring remainder step: shift in the next numerator bit
    assign div_shift = {div_rem_reg[tcgr_pkg::COL_W-1:0], div_num_reg[tcgr_pkg::COL_W]};

    always_comb
    begin
        state_next   = state_reg;
        col_next     = col_reg;
        row_next     = row_reg;
        y_next       = y_reg;
        rptr_next    = rptr_reg;
        div_cnt_next = div_cnt_reg;
        div_row_next = div_row_reg;
        row13_next   = row13_reg;
        coloff_next  = coloff_reg;
        prod_next    = prod_reg;
        addr_next    = addr_reg;
        div_num_next = div_num_reg;
        div_rem_next = div_rem_reg;
        div_den_next = div_den_reg;
        font_we      = 1'b0;
        ram_re       = 1'b0;

        unique case (state_reg)
            tcgr_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    if (item.action == tcgr_pkg::ACT_FONT)
                    begin
                        font_we = (item.glyph_index < tcgr_pkg::GIDX_W'(tcgr_pkg::GLYPH_COUNT))
                               && (item.glyph_row < tcgr_pkg::GROW_W'(tcgr_pkg::GLYPH_HEIGHT));
                    end
                    else if (item.char_code == tcgr_pkg::CODE_NEWLINE)
                    begin
                        col_next = '0;
                        if (row_wrap.need_div)
                        begin
                            div_num_next = tcgr_pkg::COL_W'(row_reg) + (tcgr_pkg::COL_W + 1)'(1);
                            div_rem_next = '0;
                            div_den_next = tcgr_pkg::COL_W'(text_rows_reg);
                            div_cnt_next = tcgr_pkg::DIV_CNT_W'(tcgr_pkg::DIV_STEPS - 1);
                            div_row_next = 1'b1;
                            state_next   = tcgr_pkg::ST_WRAP;
                        end
                        else
                        begin
                            row_next = row_wrap.value[tcgr_pkg::ROW_W-1:0];
                        end
                    end
                    else if (printable)
                    begin
                        rptr_next  = tcgr_pkg::FONT_AW'(glyph[tcgr_pkg::GIDX_W-1:0])
                                   * tcgr_pkg::FONT_AW'(tcgr_pkg::GLYPH_HEIGHT);
                        state_next = tcgr_pkg::ST_CALC;
                    end
                end
            end

            tcgr_pkg::ST_CALC:
            begin
                row13_next  = tcgr_pkg::LINE_W'(row_reg) * tcgr_pkg::LINE_W'(tcgr_pkg::GLYPH_HEIGHT);
                coloff_next = tcgr_pkg::COLOFF_W'(col_reg) * tcgr_pkg::COLOFF_W'(pixel_bytes_reg)
                            * tcgr_pkg::COLOFF_W'(tcgr_pkg::GLYPH_WIDTH);
                state_next  = tcgr_pkg::ST_MUL;
            end

            tcgr_pkg::ST_MUL:
            begin
                prod_next  = mult_full[tcgr_pkg::ADDR_W-1:0];
                state_next = tcgr_pkg::ST_SUM;
            end

            tcgr_pkg::ST_SUM:
            begin
                addr_next  = frame_base_reg + prod_reg + tcgr_pkg::ADDR_W'(coloff_reg);
                ram_re     = 1'b1;
                rptr_next  = rptr_reg + tcgr_pkg::FONT_AW'(1);
                y_next     = '0;
                state_next = tcgr_pkg::ST_EMIT;
            end

            tcgr_pkg::ST_EMIT:
            begin
                addr_next = addr_reg + tcgr_pkg::ADDR_W'(line_pitch_reg);
                y_next    = y_reg + tcgr_pkg::Y_W'(1);
                if (y_reg == LAST_Y)
                begin
                    if (col_wrap.need_div)
                    begin
                        div_num_next = {1'b0, col_reg} + (tcgr_pkg::COL_W + 1)'(1);
                        div_rem_next = '0;
                        div_den_next = text_columns_reg;
                        div_cnt_next = tcgr_pkg::DIV_CNT_W'(tcgr_pkg::DIV_STEPS - 1);
                        div_row_next = 1'b0;
                        state_next   = tcgr_pkg::ST_WRAP;
                    end
                    else
                    begin
                        col_next   = col_wrap.value;
                        state_next = tcgr_pkg::ST_IDLE;
                    end
                end
                else
                begin
                    ram_re    = 1'b1;
                    rptr_next = rptr_reg + tcgr_pkg::FONT_AW'(1);
                end
            end

            tcgr_pkg::ST_WRAP:
            begin
                div_num_next = {div_num_reg[tcgr_pkg::COL_W-1:0], 1'b0};
                if (div_shift >= {1'b0, div_den_reg})
                begin
                    div_rem_next = div_shift - {1'b0, div_den_reg};
                end
                else
                begin
                    div_rem_next = div_shift;
                end
                if (div_cnt_reg == '0)
                begin
                    if (div_row_reg)
                    begin
                        row_next = div_rem_next[tcgr_pkg::ROW_W-1:0];
                    end
                    else
                    begin
                        col_next = div_rem_next[tcgr_pkg::COL_W-1:0];
                    end
                    state_next = tcgr_pkg::ST_IDLE;
                end
                else
                begin
                    div_cnt_next = div_cnt_reg - tcgr_pkg::DIV_CNT_W'(1);
                end
            end

            default:
            begin
                state_next = tcgr_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= tcgr_pkg::ST_IDLE;
            col_reg     <= '0;
            row_reg     <= '0;
            y_reg       <= '0;
            rptr_reg    <= '0;
            div_cnt_reg <= '0;
            div_row_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            col_reg     <= col_next;
            row_reg     <= row_next;
            y_reg       <= y_next;
            rptr_reg    <= rptr_next;
            div_cnt_reg <= div_cnt_next;
            div_row_reg <= div_row_next;
        end
    end

    always_ff @(posedge clk)
    begin
        row13_reg   <= row13_next;
        coloff_reg  <= coloff_next;
        prod_reg    <= prod_next;
        addr_reg    <= addr_next;
        div_num_reg <= div_num_next;
        div_rem_reg <= div_rem_next;
        div_den_reg <= div_den_next;
    end

    // bit 7 of the font byte is the leftmost pixel
    always_comb
    begin
        for (int x = 0; x < tcgr_pkg::MASK_W; x++)
        begin
            mask[x] = ram_rdata[tcgr_pkg::FONT_DW - 1 - x];
        end
    end

    assign busy                 = (state_reg != tcgr_pkg::ST_IDLE);
    assign strobe               = (state_reg == tcgr_pkg::ST_EMIT);
    assign result.write_address = addr_reg;
    assign result.pixel_mask    = mask;
    assign result.last_row      = (y_reg == LAST_Y);

endmodule
